### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that can be compiled out as a group.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

### hdl/pip_pkg.sv
// ---------------------------------------------------------------------------
// Point-in-polygon package
// Field widths and parameter defaults shared by the vertex channel, the multiplier and the core.
// ---------------------------------------------------------------------------
package pip_pkg;

  localparam int FIELD_BITS      = 32;
  localparam int COORD_BITS_DEF  = 32;

endpackage

### hdl/pip_vertex_if.sv
// ---------------------------------------------------------------------------
// Vertex channel
// Valid/ready channel carrying one polygon vertex and the test point.
// ---------------------------------------------------------------------------
interface pip_vertex_if;
  import pip_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [FIELD_BITS-1:0] point_x;
  logic signed [FIELD_BITS-1:0] point_y;
  logic signed [FIELD_BITS-1:0] vertex_x;
  logic signed [FIELD_BITS-1:0] vertex_y;
  logic                         first;
  logic                         last;

  modport source (output valid, point_x, point_y, vertex_x, vertex_y, first, last,
                  input ready);
  modport sink (input valid, point_x, point_y, vertex_x, vertex_y, first, last,
                output ready);
endinterface

### hdl/pip_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the inside flag of one polygon.
// ---------------------------------------------------------------------------
interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

### hdl/pip_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product, reused for every edge term.
// ---------------------------------------------------------------------------
module pip_mul #(
  parameter int W = pip_pkg::COORD_BITS_DEF + 1
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] prod
);
  import pip_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

### hdl/point_in_polygon_test.sv
// ---------------------------------------------------------------------------
// Point-in-polygon test
// Crossing-number test over a stream of vertices with exact edge crossings.
// ---------------------------------------------------------------------------
// Vertices arrive one per request, with the test point sampled on the vertex
// flagged first. Every edge is tested with two products on one shared
// multiplier: a setup step forms the operand differences, the two products
// are formed in turn, and a decide step compares them and updates the parity.
// A first vertex alone is only stored, a first vertex that is also last goes
// straight to the result, any other vertex has its edge tested, and a last
// vertex also has its closing edge tested before the result is loaded. The
// result register lets the next polygon start while the previous result
// waits to be taken, but a last vertex holds in its finish step for as long
// as an earlier result is still waiting.
module point_in_polygon_test #(
  parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  pip_vertex_if.sink   vertices,
  pip_result_if.source result
);
  import pip_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SETUP  = 3'd1;
  localparam logic [2:0] ST_MULA   = 3'd2;
  localparam logic [2:0] ST_MULB   = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic signed [CW-1:0] test_x, test_y, start_x, start_y, prior_x, prior_y;
  logic signed [CW-1:0] cur_x, cur_y;
  logic signed [CW-1:0] ea_x, ea_y, eb_x, eb_y;
  logic                 parity;
  logic                 is_last;
  logic                 edge_sel;
  logic                 straddle;
  logic signed [DW-1:0] op_p, op_q, op_r, op_s;
  logic signed [PW-1:0] pa;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] mul_a, mul_b;
  logic                 accept;
  logic                 out_free;
  logic signed [CW-1:0] in_vx, in_vy, in_px, in_py;
  logic                 swap;
  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                 crosses;

  assign in_vx = vertices.vertex_x[CW-1:0];
  assign in_vy = vertices.vertex_y[CW-1:0];
  assign in_px = vertices.point_x[CW-1:0];
  assign in_py = vertices.point_y[CW-1:0];

  assign vertices.ready = (state == ST_IDLE);
  assign accept         = vertices.valid && vertices.ready;
  assign out_free       = !result.valid || result.ready;

  assign swap = ea_y > eb_y;
  assign lo_x = swap ? eb_x : ea_x;
  assign lo_y = swap ? eb_y : ea_y;
  assign hi_x = swap ? ea_x : eb_x;
  assign hi_y = swap ? ea_y : eb_y;

  assign mul_a   = (state == ST_MULA) ? op_p : op_r;
  assign mul_b   = (state == ST_MULA) ? op_q : op_s;
  assign crosses = straddle && (pa < prod);

  pip_mul #(.W(DW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (vertices.first) begin
            state_next = vertices.last ? ST_FINISH : ST_IDLE;
          end else begin
            state_next = ST_SETUP;
          end
        end
      end
      ST_SETUP:  state_next = ST_MULA;
      ST_MULA:   state_next = ST_MULB;
      ST_MULB:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (is_last && !edge_sel) begin
          state_next = ST_SETUP;
        end else if (is_last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
      parity       <= 1'b0;
      test_x       <= '0;
      test_y       <= '0;
      start_x      <= '0;
      start_y      <= '0;
      prior_x      <= '0;
      prior_y      <= '0;
    end else begin
      state <= state_next;
      if (state == ST_FINISH && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (accept) begin
        prior_x <= in_vx;
        prior_y <= in_vy;
        if (vertices.first) begin
          test_x  <= in_px;
          test_y  <= in_py;
          start_x <= in_vx;
          start_y <= in_vy;
          parity  <= 1'b0;
        end
      end
      if (state == ST_DECIDE && crosses) begin
        parity <= !parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x    <= in_vx;
      cur_y    <= in_vy;
      is_last  <= vertices.last;
      edge_sel <= 1'b0;
      ea_x     <= prior_x;
      ea_y     <= prior_y;
      eb_x     <= in_vx;
      eb_y     <= in_vy;
    end
    if (state == ST_DECIDE && is_last && !edge_sel) begin
      edge_sel <= 1'b1;
      ea_x     <= cur_x;
      ea_y     <= cur_y;
      eb_x     <= start_x;
      eb_y     <= start_y;
    end
    if (state == ST_SETUP) begin
      straddle <= (ea_y > test_y) != (eb_y > test_y);
      op_p     <= {test_x[CW-1], test_x} - {lo_x[CW-1], lo_x};
      op_q     <= {hi_y[CW-1], hi_y} - {lo_y[CW-1], lo_y};
      op_r     <= {hi_x[CW-1], hi_x} - {lo_x[CW-1], lo_x};
      op_s     <= {test_y[CW-1], test_y} - {lo_y[CW-1], lo_y};
    end
    if (state == ST_MULB) begin
      pa <= prod;
    end
    if (state == ST_FINISH && out_free) begin
      result.inside_res <= parity;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_result_from_finish, clk, rst, $rose(result.valid) |-> $past(state) == ST_FINISH, "result raised outside the finish step")
  `ASSERT_CLK(a_decide_after_mul, clk, rst, state == ST_DECIDE |-> $past(state) == ST_MULB, "compare step without both products")
  `ASSERT_CLK(a_closing_on_last, clk, rst, (state == ST_SETUP && edge_sel) |-> is_last, "closing edge tested on a vertex that is not last")
  `ASSERT_CLK(a_result_held, clk, rst, $past(result.valid && !result.ready) |-> result.valid && $stable(result.inside_res), "waiting result changed")
endmodule

### dv/tb_point_in_polygon_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Point-in-polygon test bench
// Streams directed and random polygons into the crossing-number block and
// checks each inside flag against an exact predictor kept in a scoreboard.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the block backs up into its vertex input.
// ---------------------------------------------------------------------------
module tb_point_in_polygon_test;
  import pip_pkg::*;

  localparam int CLK_HALF        = 4;
  localparam int STALL_CYCLES    = 200;
  localparam int STALL_AT        = 300;
  localparam int STEADY_FROM     = 500;
  localparam int STEADY_TO       = 700;
  localparam int VERTEX_TARGET   = 1200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 30;
  localparam logic signed [FIELD_BITS-1:0] CMIN = 32'sh8000_0000;
  localparam logic signed [FIELD_BITS-1:0] CMAX = 32'sh7fff_ffff;

  class inside_scoreboard;
    longint test_x, test_y, start_x, start_y, prev_x, prev_y;
    bit     parity;
    bit     expected_inside[$];
    int     failures;
    int     results_seen;

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%t ERROR: %s", $realtime, msg);
    endfunction

    function bit edge_crosses(longint ax, longint ay, longint bx, longint by);
      longint lo_x, lo_y, hi_x, hi_y;
      logic signed [67:0] dx_pt, dy_edge, dx_edge, dy_pt;
      if ((ay > test_y) == (by > test_y)) return 1'b0;
      if (ay > by) begin
        lo_x = bx; lo_y = by; hi_x = ax; hi_y = ay;
      end else begin
        lo_x = ax; lo_y = ay; hi_x = bx; hi_y = by;
      end
      dx_pt   = test_x - lo_x;
      dy_edge = hi_y - lo_y;
      dx_edge = hi_x - lo_x;
      dy_pt   = test_y - lo_y;
      return (dx_pt * dy_edge) < (dx_edge * dy_pt);
    endfunction

    function void note_vertex(logic signed [FIELD_BITS-1:0] px, py, vx, vy,
                              bit is_first, bit is_last);
      if (is_first) begin
        test_x  = px;
        test_y  = py;
        start_x = vx;
        start_y = vy;
        parity  = 1'b0;
      end else if (edge_crosses(prev_x, prev_y, vx, vy)) begin
        parity = !parity;
      end
      prev_x = vx;
      prev_y = vy;
      if (is_last) begin
        if (edge_crosses(vx, vy, start_x, start_y)) parity = !parity;
        expected_inside.push_back(parity);
      end
    endfunction

    function void check_inside(logic got);
      bit want;
      results_seen++;
      if (expected_inside.size() == 0) begin
        report($sformatf("inside_res=%b arrived with no polygon pending", got));
        return;
      end
      want = expected_inside.pop_front();
      if (got !== want)
        report($sformatf("inside_res expected %b, got %b (result %0d)",
                         want, got, results_seen));
    endfunction
  endclass

  logic clk;
  logic rst;
  int   vertex_count;
  bit   steady;
  bit   stall_done;

  pip_vertex_if vertices();
  pip_result_if result();
  inside_scoreboard sb = new();

  point_in_polygon_test u_dut (
    .clk      (clk),
    .rst      (rst),
    .vertices (vertices),
    .result   (result)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  initial begin
    rst               = 1'b1;
    vertices.valid    = 1'b0;
    vertices.point_x  = '0;
    vertices.point_y  = '0;
    vertices.vertex_x = '0;
    vertices.vertex_y = '0;
    vertices.first    = 1'b0;
    vertices.last     = 1'b0;
    result.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (vertices.valid && vertices.ready)
        sb.note_vertex(vertices.point_x, vertices.point_y, vertices.vertex_x,
                       vertices.vertex_y, vertices.first, vertices.last);
      if (result.valid && result.ready) sb.check_inside(result.inside_res);
    end
  end

  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || (vertices.valid && vertices.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without progress", quiet_cycles);
      $display("point_in_polygon_test: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!stall_done && vertex_count >= STALL_AT) begin
        stall_done = 1'b1;
        result.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end
      result.ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_vertex(logic signed [FIELD_BITS-1:0] px, py, vx, vy,
                             bit is_first, bit is_last);
    if (!steady && $urandom_range(99) < 15) begin
      vertices.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    vertices.valid    <= 1'b1;
    vertices.point_x  <= px;
    vertices.point_y  <= py;
    vertices.vertex_x <= vx;
    vertices.vertex_y <= vy;
    vertices.first    <= is_first;
    vertices.last     <= is_last;
    do @(posedge clk); while (!vertices.ready);
    vertex_count++;
    steady = (vertex_count >= STEADY_FROM) && (vertex_count < STEADY_TO);
  endtask

  function automatic logic signed [FIELD_BITS-1:0] pick_coord(int span);
    if (span == 0) return $urandom;
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic send_polygon();
    int n, span, k;
    logic signed [FIELD_BITS-1:0] px, py, qx, qy;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    case ($urandom_range(3))
      0: span = 8;
      1: span = 100;
      2: span = 1000000;
      default: span = 0;
    endcase
    px = pick_coord(span);
    py = pick_coord(span);
    for (k = 0; k < n; k++) begin
      qx = (k == 0) ? px : $urandom;
      qy = (k == 0) ? py : $urandom;
      send_vertex(qx, qy, pick_coord(span), pick_coord(span), k == 0, k == n - 1);
    end
  endtask

  initial begin
    int span;
    @(negedge rst);
    @(posedge clk);
    // A vertex before any first vertex works from the cleared state.
    send_vertex(0, 0, 5, -3, 1'b0, 1'b0);
    send_vertex(0, 0, -4, 7, 1'b0, 1'b1);
    // Square around the origin.
    send_vertex(0, 0, -10, -10, 1'b1, 1'b0);
    send_vertex(0, 0, 10, -10, 1'b0, 1'b0);
    send_vertex(0, 0, 10, 10, 1'b0, 1'b0);
    send_vertex(0, 0, -10, 10, 1'b0, 1'b1);
    // Triangles spanning the full coordinate range.
    send_vertex(0, 0, CMIN, CMIN, 1'b1, 1'b0);
    send_vertex(CMAX, CMAX, CMAX, CMIN, 1'b0, 1'b0);
    send_vertex(CMIN, CMIN, 0, CMAX, 1'b0, 1'b1);
    send_vertex(CMIN, CMAX, CMAX, CMAX, 1'b1, 1'b0);
    send_vertex(0, 0, CMIN, 0, 1'b0, 1'b0);
    send_vertex(0, 0, CMAX, CMIN, 1'b0, 1'b1);
    // A polygon of a single vertex.
    send_vertex(3, 3, 3, 3, 1'b1, 1'b1);
    // Diamond with two vertices on the point's y.
    send_vertex(-10, 0, 0, -5, 1'b1, 1'b0);
    send_vertex(0, 0, 5, 0, 1'b0, 1'b0);
    send_vertex(0, 0, 0, 5, 1'b0, 1'b0);
    send_vertex(0, 0, -5, 0, 1'b0, 1'b1);
    // Point lying on the right edge of a square.
    send_vertex(4, 2, 0, 0, 1'b1, 1'b0);
    send_vertex(0, 0, 4, 0, 1'b0, 1'b0);
    send_vertex(0, 0, 4, 4, 1'b0, 1'b0);
    send_vertex(0, 0, 0, 4, 1'b0, 1'b1);

    while (vertex_count < VERTEX_TARGET) begin
      if ($urandom_range(9) == 0) begin
        span = $urandom_range(1) ? 8 : 0;
        send_vertex($urandom, $urandom, pick_coord(span), pick_coord(span),
                    $urandom_range(1), $urandom_range(1));
      end else begin
        send_polygon();
      end
    end
    vertices.valid <= 1'b0;

    while (sb.expected_inside.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d vertices and checked %0d inside flags, with a %0d-cycle result stall.",
             vertex_count, sb.results_seen, STALL_CYCLES);
    if (sb.failures == 0 && sb.expected_inside.size() == 0) begin
      $display("point_in_polygon_test: match");
    end else begin
      $display("%0d failures, %0d results outstanding", sb.failures,
               sb.expected_inside.size());
      $display("point_in_polygon_test: mismatch");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_vertex_if.sv
hdl/pip_result_if.sv
hdl/pip_mul.sv
hdl/point_in_polygon_test.sv
dv/tb_point_in_polygon_test.sv
